[hw/rtl/bdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque with erase: transaction
// payloads, request and status codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_ERASE      = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic               is_empty;
        logic [4:0]         count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       add_head;
        logic       add_tail;
        logic       del_head;
        logic       del_tail;
        logic       status_we;
        logic [1:0] status_val;
        logic       scan_rd;
        logic       idx_inc;
        logic       shift_rd;
        logic       shift_wr;
        logic       erase_done;
        logic       rd_front;
        logic       rd_back;
        logic       load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] req;
        logic       full;
        logic       empty;
        logic       match;
        logic       scan_last;
        logic       shift_last;
        logic       out_free;
    } t_dp_sts;

endpackage

[hw/rtl/bdq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer for the deque: decodes each request, steps the erase search and
// shift, reads back front and back, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bdq_pkg::t_dp_sts i_sts,
    output bdq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_EXEC     = 9'b000000010,
        S_SCAN_RD  = 9'b000000100,
        S_SCAN_CMP = 9'b000001000,
        S_SHIFT_RD = 9'b000010000,
        S_SHIFT_WR = 9'b000100000,
        S_RD_FRONT = 9'b001000000,
        S_RD_BACK  = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.status_we  = 1'b1;
                o_cmd.status_val = bdq_pkg::STATUS_OK;
                n_state          = S_RD_FRONT;
                unique case (i_sts.req)
                    bdq_pkg::REQ_PUSH_FRONT: begin
                        if (i_sts.full) begin
                            o_cmd.status_val = bdq_pkg::STATUS_FULL;
                        end else begin
                            o_cmd.add_head = 1'b1;
                        end
                    end
                    bdq_pkg::REQ_PUSH_BACK: begin
                        if (i_sts.full) begin
                            o_cmd.status_val = bdq_pkg::STATUS_FULL;
                        end else begin
                            o_cmd.add_tail = 1'b1;
                        end
                    end
                    bdq_pkg::REQ_POP_FRONT: begin
                        if (i_sts.empty) begin
                            o_cmd.status_val = bdq_pkg::STATUS_EMPTY;
                        end else begin
                            o_cmd.del_head = 1'b1;
                        end
                    end
                    bdq_pkg::REQ_POP_BACK: begin
                        if (i_sts.empty) begin
                            o_cmd.status_val = bdq_pkg::STATUS_EMPTY;
                        end else begin
                            o_cmd.del_tail = 1'b1;
                        end
                    end
                    bdq_pkg::REQ_ERASE: begin
                        // not found until a match clears it
                        o_cmd.status_val = bdq_pkg::STATUS_NOTFOUND;
                        if (!i_sts.empty) begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    if (i_sts.scan_last) begin
                        o_cmd.erase_done = 1'b1;
                        n_state          = S_RD_FRONT;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else if (i_sts.scan_last) begin
                    n_state = S_RD_FRONT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                o_cmd.shift_rd = 1'b1;
                n_state        = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                if (i_sts.shift_last) begin
                    o_cmd.erase_done = 1'b1;
                    n_state          = S_RD_FRONT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SHIFT_RD;
                end
            end
            S_RD_FRONT: begin
                o_cmd.rd_front = 1'b1;
                n_state        = S_RD_BACK;
            end
            S_RD_BACK: begin
                o_cmd.rd_back = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[hw/rtl/bdq_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath for the deque: circular element store with one write and one
// registered read port, front index, element count, search index and the
// result register.
// ----------------------------------------------------------------------------
module bdq_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdq_pkg::t_dp_cmd   i_cmd,
    output bdq_pkg::t_dp_sts   o_sts,
    input  bdq_pkg::t_in_item  i_in_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output bdq_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [DATA_WIDTH-1:0] r_front_val;
    logic [DATA_WIDTH-1:0] r_val;
    logic [2:0]            r_req;
    logic [1:0]            r_status;
    logic [AW-1:0]         r_front;
    logic [AW-1:0]         r_idx;
    logic [CW-1:0]         r_count;
    logic                  r_out_valid;
    bdq_pkg::t_out_item    r_out;
    bdq_pkg::t_out_item    n_out;

    logic [63:0]           w_in_ext;
    logic [DATA_WIDTH-1:0] w_in_val;
    logic [AW-1:0]         w_front_dec;
    logic [CW:0]           w_idx_p1;
    logic [CW:0]           w_idx_p2;
    logic [CW-1:0]         w_cnt_m1;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [63:0]           w_front_ext;
    logic [63:0]           w_back_ext;
    logic [CW+4:0]         w_cnt_ext;
    logic                  w_empty;

    // circular position: base plus offset, offset below depth
    function automatic logic [AW-1:0] f_wrap_add(input logic [AW-1:0] base,
                                                 input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // sign extend to 64 then cut to the store width
    assign w_in_ext = {{32{i_in_data.value[31]}}, i_in_data.value};
    assign w_in_val = w_in_ext[DATA_WIDTH-1:0];

    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign w_idx_p1    = (CW+1)'(r_idx) + (CW+1)'(1);
    assign w_idx_p2    = (CW+1)'(r_idx) + (CW+1)'(2);
    assign w_cnt_m1    = (r_count == '0) ? '0 : r_count - CW'(1);
    assign w_empty     = (r_count == '0);

    always_comb begin
        w_wr_en   = i_cmd.add_head | i_cmd.add_tail | i_cmd.shift_wr;
        w_wr_data = i_cmd.shift_wr ? r_rd_data : r_val;
        if (i_cmd.add_head) begin
            w_wr_addr = w_front_dec;
        end else if (i_cmd.add_tail) begin
            w_wr_addr = f_wrap_add(r_front, r_count);
        end else begin
            w_wr_addr = f_wrap_add(r_front, CW'(r_idx));
        end
    end

    always_comb begin
        w_rd_en = i_cmd.scan_rd | i_cmd.shift_rd | i_cmd.rd_front | i_cmd.rd_back;
        if (i_cmd.scan_rd) begin
            w_rd_addr = f_wrap_add(r_front, CW'(r_idx));
        end else if (i_cmd.shift_rd) begin
            w_rd_addr = f_wrap_add(r_front, w_idx_p1[CW-1:0]);
        end else if (i_cmd.rd_back) begin
            w_rd_addr = f_wrap_add(r_front, w_cnt_m1);
        end else begin
            w_rd_addr = r_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.add_head) begin
                r_front <= w_front_dec;
                r_count <= r_count + CW'(1);
            end else if (i_cmd.add_tail) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.del_head) begin
                r_front <= f_wrap_add(r_front, CW'(1));
                r_count <= r_count - CW'(1);
            end else if (i_cmd.del_tail || i_cmd.erase_done) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data.req_type;
            r_val <= w_in_val;
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.erase_done) begin
            r_status <= bdq_pkg::STATUS_OK;
        end else if (i_cmd.status_we) begin
            r_status <= i_cmd.status_val;
        end
        if (i_cmd.rd_back) begin
            r_front_val <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    // read data holds the back element while the result is assembled
    assign w_front_ext = 64'(r_front_val);
    assign w_back_ext  = 64'(r_rd_data);
    assign w_cnt_ext   = (CW+5)'(r_count);

    always_comb begin
        n_out.status      = r_status;
        n_out.front_value = w_empty ? '0 : w_front_ext[31:0];
        n_out.back_value  = w_empty ? '0 : w_back_ext[31:0];
        n_out.is_empty    = w_empty;
        n_out.count       = w_cnt_ext[4:0];
    end

    assign o_sts.req        = r_req;
    assign o_sts.full       = (r_count == CW'(DEPTH));
    assign o_sts.empty      = w_empty;
    assign o_sts.match      = (r_rd_data == r_val);
    assign o_sts.scan_last  = (w_idx_p1 == (CW+1)'(r_count));
    assign o_sts.shift_last = (w_idx_p2 == (CW+1)'(r_count));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/bounded_deque_with_erase_core.sv]
`timescale 1ns / 1ps
// push, pop, rejected and unused requests run execute, front read, back read and done,
// and the next request is taken only after the result is loaded into the output register
// erase adds a scan read and compare per element searched and a shift read and write per
// element moved, since the element store has a single read port with registered read data
// reset clears the sequencer, front index, count and output valid; store contents are kept
// ----------------------------------------------------------------------------
// bounded_deque_with_erase_core
// Bounded double-ended queue of signed values with push and pop at either
// end and erase of the first element equal to a given value.
// ----------------------------------------------------------------------------
module bounded_deque_with_erase_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bdq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bdq_pkg::t_out_item o_out_data
);

    bdq_pkg::t_dp_cmd w_cmd;
    bdq_pkg::t_dp_sts w_sts;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bdq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[hw/rtl/bdq_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checks for the deque core, attached by bind.
// ----------------------------------------------------------------------------
module bdq_chk #(
    parameter int DEPTH = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input bdq_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_empty |->
            o_out_data.front_value == '0 && o_out_data.back_value == '0)
        else $error("empty result with nonzero front or back");

    a_status_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == bdq_pkg::STATUS_EMPTY |->
            o_out_data.is_empty)
        else $error("empty status on a nonempty deque");

    a_status_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == bdq_pkg::STATUS_FULL |->
            (DEPTH >= 32) || (o_out_data.count == 5'(DEPTH)))
        else $error("full status below capacity");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken while one is in flight");

endmodule

bind bounded_deque_with_erase_core bdq_chk #(
    .DEPTH (DEPTH)
) u_bdq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[bench/bounded_deque_with_erase_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_erase_core_test
// Self-checking bench for the bounded deque core. A short scripted sequence
// covers empty, full, extreme values and erase at the front, middle and back.
// It is followed by random runs of fill, drain, mixed and erase-heavy traffic.
// Each result is checked field by field against a scripted expectation or an
// in-bench deque model, with random request gaps and random result stalls.
// ----------------------------------------------------------------------------
module bounded_deque_with_erase_core_test;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1000;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [2:0] REQ_SPARE_A = 3'd5;
    localparam logic [2:0] REQ_SPARE_B = 3'd6;
    localparam logic [2:0] REQ_SPARE_C = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_ERASE} t_mode;

    typedef struct {
        logic [2:0]         req;
        logic signed [31:0] value;
        int                 reps;
        bit                 typed;
        bdq_pkg::t_out_item want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n    = 1'b0;
    logic               in_valid   = 1'b0;
    logic               out_ready  = 1'b0;
    bdq_pkg::t_in_item  in_data    = '0;
    logic               in_ready;
    logic               out_valid;
    bdq_pkg::t_out_item out_data;

    // deque model state
    logic signed [31:0] model_store [DEPTH];
    logic [3:0]         model_front;
    logic [4:0]         model_count;

    bdq_pkg::t_out_item pending_results [$];
    t_row               script [$];
    bdq_pkg::t_out_item got_want;
    int                 error_count = 0;
    int                 idle_cycles = 0;
    bit                 quiet_in    = 1'b0;

    bounded_deque_with_erase_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bdq_pkg::t_out_item deque_apply(input bdq_pkg::t_in_item it);
        bdq_pkg::t_out_item r;
        logic [1:0]         st;
        logic [3:0]         pos;
        int                 i;
        int                 k;
        st = bdq_pkg::STATUS_OK;
        case (it.req_type)
            bdq_pkg::REQ_PUSH_FRONT: begin
                if (model_count >= DEPTH) begin
                    st = bdq_pkg::STATUS_FULL;
                end else begin
                    model_front = model_front - 4'd1;
                    model_store[model_front] = it.value;
                    model_count++;
                end
            end
            bdq_pkg::REQ_PUSH_BACK: begin
                if (model_count >= DEPTH) begin
                    st = bdq_pkg::STATUS_FULL;
                end else begin
                    pos = model_front + model_count[3:0];
                    model_store[pos] = it.value;
                    model_count++;
                end
            end
            bdq_pkg::REQ_POP_FRONT: begin
                if (model_count == 0) begin
                    st = bdq_pkg::STATUS_EMPTY;
                end else begin
                    model_front = model_front + 4'd1;
                    model_count--;
                end
            end
            bdq_pkg::REQ_POP_BACK: begin
                if (model_count == 0) st = bdq_pkg::STATUS_EMPTY;
                else model_count--;
            end
            bdq_pkg::REQ_ERASE: begin
                st = bdq_pkg::STATUS_NOTFOUND;
                for (i = 0; i < model_count; i++) begin
                    pos = model_front + 4'(i);
                    if (model_store[pos] == it.value) begin
                        // close the gap toward the front
                        for (k = i; k + 1 < model_count; k++) begin
                            model_store[4'(model_front + 4'(k))] =
                                model_store[4'(model_front + 4'(k + 1))];
                        end
                        model_count--;
                        st = bdq_pkg::STATUS_OK;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.status = st;
        r.count  = model_count;
        if (model_count == 0) begin
            r.front_value = '0;
            r.back_value  = '0;
            r.is_empty    = 1'b1;
        end else begin
            pos           = model_front + 4'(model_count - 5'd1);
            r.front_value = model_store[model_front];
            r.back_value  = model_store[pos];
            r.is_empty    = 1'b0;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        // small pool gives duplicates and erase hits
        if (r < 5) return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        return $signed($urandom);
    endfunction

    function automatic logic signed [31:0] live_value();
        logic [3:0] pos;
        if (model_count == 0) return pick_value();
        pos = model_front + 4'($urandom_range(0, model_count - 1));
        return model_store[pos];
    endfunction

    function automatic logic [2:0] next_req(input t_mode mode);
        int r;
        int t0;
        int t1;
        int t2;
        int t3;
        int t4;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  begin t0 = 35; t1 = 75; t2 = 82; t3 = 88; t4 = 98; end
            MODE_DRAIN: begin t0 = 10; t1 = 20; t2 = 50; t3 = 80; t4 = 97; end
            MODE_MIX:   begin t0 = 20; t1 = 40; t2 = 55; t3 = 70; t4 = 97; end
            default:    begin t0 = 25; t1 = 50; t2 = 55; t3 = 60; t4 = 98; end
        endcase
        if (r < t0) return bdq_pkg::REQ_PUSH_FRONT;
        if (r < t1) return bdq_pkg::REQ_PUSH_BACK;
        if (r < t2) return bdq_pkg::REQ_POP_FRONT;
        if (r < t3) return bdq_pkg::REQ_POP_BACK;
        if (r < t4) return bdq_pkg::REQ_ERASE;
        case ($urandom_range(0, 2))
            0: return REQ_SPARE_A;
            1: return REQ_SPARE_B;
            default: return REQ_SPARE_C;
        endcase
    endfunction

    task automatic add_row(input logic [2:0] req, input logic signed [31:0] value,
                           input int reps, input bit typed,
                           input bdq_pkg::t_out_item want);
        t_row row;
        row.req   = req;
        row.value = value;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        script.insert(script.size(), row);
    endtask

    // present one transaction and wait for its acceptance
    task automatic send(input bdq_pkg::t_in_item it, input bit typed,
                        input bdq_pkg::t_out_item want, input int gap);
        bdq_pkg::t_out_item p;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        p = deque_apply(it);
        pending_results.insert(pending_results.size(), typed ? want : p);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // result side stalls
    initial begin
        int stall_left;
        int cycles;
        bit quiet;
        stall_left = 0;
        cycles     = 0;
        quiet      = 1'b0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing pending, expected none actual %h",
                         $time, out_data);
            end else begin
                got_want = pending_results[0];
                pending_results.delete(0);
                check_field("status", 32'(got_want.status), 32'(out_data.status));
                check_field("front_value", got_want.front_value, out_data.front_value);
                check_field("back_value", got_want.back_value, out_data.back_value);
                check_field("is_empty", 32'(got_want.is_empty), 32'(out_data.is_empty));
                check_field("count", 32'(got_want.count), 32'(out_data.count));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bdq_pkg::t_in_item it;
        t_mode             mode;
        int                sent;
        int                len;
        int                n;
        bit                pressed;
        model_front = '0;
        model_count = '0;
        for (n = 0; n < DEPTH; n++) model_store[n] = '0;

        // empty sequence, spare codes, extremes, erase at front, middle and back, full
        add_row(bdq_pkg::REQ_POP_FRONT, 32'sd0, 1, 1'b1,
                '{bdq_pkg::STATUS_EMPTY, 32'sd0, 32'sd0, 1'b1, 5'd0});
        add_row(bdq_pkg::REQ_POP_BACK, 32'sd0, 1, 1'b1,
                '{bdq_pkg::STATUS_EMPTY, 32'sd0, 32'sd0, 1'b1, 5'd0});
        add_row(bdq_pkg::REQ_ERASE, 32'sd0, 1, 1'b1,
                '{bdq_pkg::STATUS_NOTFOUND, 32'sd0, 32'sd0, 1'b1, 5'd0});
        add_row(REQ_SPARE_A, -32'sd1, 1, 1'b1,
                '{bdq_pkg::STATUS_OK, 32'sd0, 32'sd0, 1'b1, 5'd0});
        add_row(REQ_SPARE_B, VAL_MAX, 1, 1'b1,
                '{bdq_pkg::STATUS_OK, 32'sd0, 32'sd0, 1'b1, 5'd0});
        add_row(REQ_SPARE_C, VAL_MIN, 1, 1'b1,
                '{bdq_pkg::STATUS_OK, 32'sd0, 32'sd0, 1'b1, 5'd0});
        add_row(bdq_pkg::REQ_PUSH_FRONT, VAL_MIN, 1, 1'b1,
                '{bdq_pkg::STATUS_OK, VAL_MIN, VAL_MIN, 1'b0, 5'd1});
        add_row(bdq_pkg::REQ_PUSH_BACK, VAL_MAX, 1, 1'b1,
                '{bdq_pkg::STATUS_OK, VAL_MIN, VAL_MAX, 1'b0, 5'd2});
        add_row(bdq_pkg::REQ_ERASE, 32'sd5, 1, 1'b1,
                '{bdq_pkg::STATUS_NOTFOUND, VAL_MIN, VAL_MAX, 1'b0, 5'd2});
        add_row(bdq_pkg::REQ_ERASE, VAL_MAX, 1, 1'b1,
                '{bdq_pkg::STATUS_OK, VAL_MIN, VAL_MIN, 1'b0, 5'd1});
        add_row(bdq_pkg::REQ_ERASE, VAL_MIN, 1, 1'b1,
                '{bdq_pkg::STATUS_OK, 32'sd0, 32'sd0, 1'b1, 5'd0});
        add_row(bdq_pkg::REQ_PUSH_BACK, 32'sd100, DEPTH, 1'b0, '0);
        add_row(bdq_pkg::REQ_PUSH_FRONT, -32'sd7, 1, 1'b1,
                '{bdq_pkg::STATUS_FULL, 32'sd100, 32'sd115, 1'b0, 5'd16});
        add_row(bdq_pkg::REQ_PUSH_BACK, 32'sd1, 1, 1'b1,
                '{bdq_pkg::STATUS_FULL, 32'sd100, 32'sd115, 1'b0, 5'd16});
        add_row(bdq_pkg::REQ_ERASE, 32'sd107, 1, 1'b0, '0);
        add_row(bdq_pkg::REQ_ERASE, 32'sd115, 1, 1'b0, '0);
        add_row(bdq_pkg::REQ_ERASE, 32'sd100, 1, 1'b0, '0);
        add_row(bdq_pkg::REQ_POP_FRONT, 32'sd0, 1, 1'b0, '0);
        add_row(bdq_pkg::REQ_POP_BACK, 32'sd0, 1, 1'b0, '0);
        add_row(bdq_pkg::REQ_PUSH_FRONT, -32'sd1, 1, 1'b0, '0);
        add_row(bdq_pkg::REQ_PUSH_BACK, -32'sd1, 1, 1'b0, '0);
        add_row(bdq_pkg::REQ_ERASE, -32'sd1, 1, 1'b0, '0);
        add_row(REQ_SPARE_A, 32'sd3, 1, 1'b0, '0);
        add_row(bdq_pkg::REQ_POP_FRONT, 32'sd0, 12, 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            for (n = 0; n < script[r].reps; n++) begin
                it.req_type = script[r].req;
                it.value    = script[r].value + n;
                send(it, script[r].typed, script[r].want, pick_gap());
            end
        end
        hold_until_drained();

        sent    = 0;
        pressed = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            mode     = t_mode'($urandom_range(0, 3));
            quiet_in = ($urandom_range(0, 3) == 0);
            len      = $urandom_range(30, 60);
            for (n = 0; n < len && sent < RANDOM_ITEMS; n++) begin
                it.req_type = next_req(mode);
                if (it.req_type == bdq_pkg::REQ_ERASE && $urandom_range(0, 9) < 6) begin
                    it.value = live_value();
                end else begin
                    it.value = pick_value();
                end
                send(it, 1'b0, '0, quiet_in ? 0 : pick_gap());
                sent++;
            end
            if (!pressed && sent >= RANDOM_ITEMS / 2) begin
                pressed = 1'b1;
                hold_until_drained();
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
